@@ src/brc_pkg.sv @@
// shared types and constants for the brace framed command receiver
`timescale 1ns / 1ps

package brc_pkg;

    // frame delimiters and command letters
    localparam logic [7:0] CHAR_OPEN  = 8'h7B;
    localparam logic [7:0] CHAR_CLOSE = 8'h7D;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_G     = 8'h47;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_M     = 8'h4D;
    localparam logic [7:0] CHAR_E     = 8'h45;

    // meter value after reset
    localparam logic [7:0] METER_RESET = 8'd100;

    // frame kind codes
    localparam logic [2:0] KIND_UNKNOWN = 3'd0;
    localparam logic [2:0] KIND_SENSOR  = 3'd1;
    localparam logic [2:0] KIND_GO      = 3'd2;
    localparam logic [2:0] KIND_ALERT   = 3'd3;
    localparam logic [2:0] KIND_PAYMENT = 3'd4;
    localparam logic [2:0] KIND_END     = 3'd5;

    // decode looks at the command byte and eight bytes after it
    localparam int ALERT_BYTES  = 8;
    localparam int DECODE_BYTES = ALERT_BYTES + 1;

    // one received byte
    typedef logic [7:0] t_rx;

    // one decoded result
    typedef struct packed {
        logic [2:0]  frame_kind;
        logic [7:0]  hunger_level;
        logic [7:0]  happy_level;
        logic [7:0]  thirst_level;
        logic [15:0] money_total;
        logic [63:0] alert_text;
        logic        refresh_flag;
        logic        hash_go_event;
    } t_result;

    // frame collector view handed to the decoder
    typedef struct packed {
        logic                              closing;
        logic [DECODE_BYTES-1:0][7:0]      bytes;
    } t_frame_evt;

endpackage

@@ src/brc_stream_if.sv @@
// valid/ready stream channel with a typed payload
`timescale 1ns / 1ps

interface brc_stream_if #(
    parameter type t_payload = logic [7:0]
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/brc_frame.sv @@
// frame tracking and byte buffer
`timescale 1ns / 1ps

module brc_frame #(
    parameter int BUFFER_BYTES = 11
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_step,
    input  brc_pkg::t_rx        i_byte,
    output brc_pkg::t_frame_evt o_evt
);
    import brc_pkg::*;

    localparam int FILL_W = $clog2(BUFFER_BYTES + 1);

    logic              r_in_frame;
    logic [FILL_W-1:0] r_fill;
    logic [7:0]        r_buf [BUFFER_BYTES];

    // close seen while a frame is open
    always_comb begin
        o_evt.closing = i_valid && r_in_frame && (i_byte == CHAR_CLOSE);
        for (int k = 0; k < DECODE_BYTES; k++) begin
            o_evt.bytes[k] = r_buf[k];
        end
    end

    // frame state and buffer fill, overflow bytes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_fill     <= '0;
            for (int i = 0; i < BUFFER_BYTES; i++) begin
                r_buf[i] <= 8'd0;
            end
        end else if (i_step) begin
            if (i_byte == CHAR_OPEN) begin
                r_in_frame <= 1'b1;
                r_fill     <= '0;
            end else if (r_in_frame) begin
                if (i_byte == CHAR_CLOSE) begin
                    r_in_frame <= 1'b0;
                    r_fill     <= '0;
                end else if (r_fill < FILL_W'(BUFFER_BYTES)) begin
                    for (int i = 0; i < BUFFER_BYTES; i++) begin
                        if (r_fill == FILL_W'(i)) begin
                            r_buf[i] <= i_byte;
                        end
                    end
                    r_fill <= r_fill + FILL_W'(1);
                end
            end
        end
    end
endmodule

@@ src/brc_decode.sv @@
// command decode, meter and money stores, result register
`timescale 1ns / 1ps

module brc_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  brc_pkg::t_frame_evt i_evt,
    brc_stream_if.source        o_res
);
    import brc_pkg::*;

    logic [7:0]  r_hunger, r_happy, r_thirst;
    logic [15:0] r_money;
    logic [63:0] r_alert;
    logic        r_out_valid;
    t_result     r_out;

    logic [7:0]  n_hunger, n_happy, n_thirst;
    logic [15:0] n_money;
    logic [63:0] n_alert;
    t_result     n_out;

    // decode by command byte
    always_comb begin
        n_hunger = r_hunger;
        n_happy  = r_happy;
        n_thirst = r_thirst;
        n_money  = r_money;
        n_alert  = r_alert;
        n_out    = '0;
        unique case (i_evt.bytes[0])
            CHAR_S: begin
                n_out.frame_kind   = KIND_SENSOR;
                n_hunger           = i_evt.bytes[1];
                n_happy            = i_evt.bytes[2];
                n_thirst           = i_evt.bytes[3];
                n_out.refresh_flag = (n_hunger != r_hunger) || (n_happy != r_happy)
                                     || (n_thirst != r_thirst);
            end
            CHAR_G: begin
                n_out.frame_kind = KIND_GO;
                n_money          = {i_evt.bytes[2], i_evt.bytes[3]};
            end
            CHAR_A: begin
                n_out.frame_kind    = KIND_ALERT;
                for (int i = 0; i < ALERT_BYTES; i++) begin
                    n_alert[8*i +: 8] = i_evt.bytes[i+1];
                end
                n_out.hash_go_event = 1'b1;
            end
            CHAR_M: begin
                n_out.frame_kind   = KIND_PAYMENT;
                n_money            = r_money + {i_evt.bytes[1], i_evt.bytes[2]};
                n_out.refresh_flag = 1'b1;
            end
            CHAR_E: begin
                n_out.frame_kind = KIND_END;
            end
            default: begin
                n_out.frame_kind = KIND_UNKNOWN;
            end
        endcase
        n_out.hunger_level = n_hunger;
        n_out.happy_level  = n_happy;
        n_out.thirst_level = n_thirst;
        n_out.money_total  = n_money;
        n_out.alert_text   = n_alert;
    end

    // stores and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunger    <= METER_RESET;
            r_happy     <= METER_RESET;
            r_thirst    <= METER_RESET;
            r_money     <= 16'd0;
            r_alert     <= 64'd0;
            r_out_valid <= 1'b0;
        end else if (i_fire) begin
            r_hunger    <= n_hunger;
            r_happy     <= n_happy;
            r_thirst    <= n_thirst;
            r_money     <= n_money;
            r_alert     <= n_alert;
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;
endmodule

@@ src/brace_framed_command_receiver.sv @@
// top level of the brace framed command receiver
`timescale 1ns / 1ps

// Takes one received byte per cycle on i_rx while i_rx.ready is high, and emits one
// result on o_res for each frame closed by '}'. A byte goes first into an input
// register; from there it updates the frame buffer or, for a closing brace, is
// decoded into the result register, which then offers the result. The input
// register is freed every cycle unless it holds a closing brace while the result
// register still holds an untaken result; outside reset, only then does i_rx.ready
// drop. Sustained rate is one byte per cycle while results are taken.
module brace_framed_command_receiver #(
    parameter int BUFFER_BYTES = 11
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    brc_stream_if.sink   i_rx,
    brc_stream_if.source o_res
);
    import brc_pkg::*;

    logic       r_in_valid;
    t_rx        r_in_byte;
    t_frame_evt frame_evt;
    logic       out_free;
    logic       consume;

    // the held byte moves on unless it closes a frame and the result slot is full
    assign out_free   = !o_res.valid || o_res.ready;
    assign consume    = r_in_valid && (!frame_evt.closing || out_free);
    assign i_rx.ready = i_rst_n && (!r_in_valid || consume);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.data;
        end
    end

    // frame collector
    brc_frame #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_step  (consume),
        .i_byte  (r_in_byte),
        .o_evt   (frame_evt)
    );

    // decoder and result register
    brc_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (consume && frame_evt.closing),
        .i_evt   (frame_evt),
        .o_res   (o_res)
    );
endmodule

@@ src/brc_checker.sv @@
// port level checks for the brace framed command receiver
`timescale 1ns / 1ps

module brc_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_res_valid,
    input logic             i_res_ready,
    input brc_pkg::t_result i_res_data
);
    import brc_pkg::*;

    // a stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_data))
        else $error("result changed while stalled");

    // hash start only on alert frames
    a_hash_alert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_data.hash_go_event |-> i_res_data.frame_kind == KIND_ALERT)
        else $error("hash start on non-alert frame");

    // refresh only on sensor or payment frames
    a_refresh_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_data.refresh_flag
        |-> i_res_data.frame_kind == KIND_SENSOR || i_res_data.frame_kind == KIND_PAYMENT)
        else $error("refresh on wrong frame kind");

    // payments always refresh
    a_payment_refresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_data.frame_kind == KIND_PAYMENT |-> i_res_data.refresh_flag)
        else $error("payment without refresh");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");
endmodule

bind brace_framed_command_receiver brc_checker u_brc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);

@@ test/testbench.sv @@
// self-checking testbench for the brace framed command receiver
`timescale 1ns / 1ps

module testbench;
    import brc_pkg::*;

    localparam int BUFFER_BYTES  = 11;
    localparam int RANDOM_BYTES  = 1750;
    localparam int MAX_PRINTED   = 50;

    logic i_clk = 1'b0;
    logic i_rst_n;

    brc_stream_if #(.t_payload(t_rx))     rx_if ();
    brc_stream_if #(.t_payload(t_result)) res_if ();

    brace_framed_command_receiver #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    // frame decoder prediction and queue of decoded frames still owed
    class frame_scoreboard;
        logic        in_frame;
        int          fill_idx;
        t_rx         frame_bytes [BUFFER_BYTES];
        logic [7:0]  hunger;
        logic [7:0]  happy;
        logic [7:0]  thirst;
        logic [15:0] money;
        logic [63:0] alert;
        t_result     decoded_q [$];
        int          errors;

        function new();
            in_frame = 1'b0;
            fill_idx = 0;
            foreach (frame_bytes[i]) frame_bytes[i] = '0;
            hunger = METER_RESET;
            happy  = METER_RESET;
            thirst = METER_RESET;
            money  = '0;
            alert  = '0;
            errors = 0;
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_PRINTED) $display("%0t ns: %s", $time, what);
        endtask

        // update the frame state with one accepted request
        function void absorb_byte(t_rx b);
            t_result want;
            if (b == CHAR_OPEN) begin
                in_frame = 1'b1;
                fill_idx = 0;
                return;
            end
            if (!in_frame) return;
            if (b != CHAR_CLOSE) begin
                // bytes past the buffer end are dropped
                if (fill_idx < BUFFER_BYTES) begin
                    frame_bytes[fill_idx] = b;
                    fill_idx++;
                end
                return;
            end
            in_frame = 1'b0;
            fill_idx = 0;
            want = '0;
            // decode on the command byte, stale bytes included
            case (frame_bytes[0])
                CHAR_S: begin
                    want.frame_kind   = KIND_SENSOR;
                    want.refresh_flag = (frame_bytes[1] != hunger) ||
                                        (frame_bytes[2] != happy) ||
                                        (frame_bytes[3] != thirst);
                    hunger = frame_bytes[1];
                    happy  = frame_bytes[2];
                    thirst = frame_bytes[3];
                end
                CHAR_G: begin
                    want.frame_kind = KIND_GO;
                    money = {frame_bytes[2], frame_bytes[3]};
                end
                CHAR_A: begin
                    want.frame_kind    = KIND_ALERT;
                    want.hash_go_event = 1'b1;
                    for (int i = 0; i < ALERT_BYTES; i++) alert[8*i +: 8] = frame_bytes[i+1];
                end
                CHAR_M: begin
                    want.frame_kind   = KIND_PAYMENT;
                    want.refresh_flag = 1'b1;
                    money = money + {frame_bytes[1], frame_bytes[2]};
                end
                CHAR_E: want.frame_kind = KIND_END;
                default: want.frame_kind = KIND_UNKNOWN;
            endcase
            want.hunger_level = hunger;
            want.happy_level  = happy;
            want.thirst_level = thirst;
            want.money_total  = money;
            want.alert_text   = alert;
            decoded_q.push_back(want);
        endfunction

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        // compare one delivered result with the oldest decoded frame
        task check_result(t_result got);
            t_result want;
            if (decoded_q.size() == 0) begin
                report_mismatch($sformatf("result with no closed frame, kind %0d",
                                          got.frame_kind));
                return;
            end
            want = decoded_q.pop_front();
            compare_field("frame_kind",    64'(got.frame_kind),    64'(want.frame_kind));
            compare_field("hunger_level",  64'(got.hunger_level),  64'(want.hunger_level));
            compare_field("happy_level",   64'(got.happy_level),   64'(want.happy_level));
            compare_field("thirst_level",  64'(got.thirst_level),  64'(want.thirst_level));
            compare_field("money_total",   64'(got.money_total),   64'(want.money_total));
            compare_field("alert_text",    got.alert_text,         want.alert_text);
            compare_field("refresh_flag",  64'(got.refresh_flag),  64'(want.refresh_flag));
            compare_field("hash_go_event", 64'(got.hash_go_event), 64'(want.hash_go_event));
        endtask
    endclass

    frame_scoreboard sb = new();

    int  bytes_counted;
    bit  calm = 1'b0;

    // stray close, empty frame, short sensor frame, nested open,
    // full-scale payment, end frame, alert from stale bytes
    t_rx directed_bytes [24] = '{
        CHAR_CLOSE, 8'h55,
        CHAR_OPEN, CHAR_CLOSE,
        CHAR_OPEN, CHAR_S, 8'hFF, 8'h00, CHAR_CLOSE,
        CHAR_OPEN, CHAR_OPEN, CHAR_G, CHAR_CLOSE,
        CHAR_OPEN, CHAR_M, 8'hFF, 8'hFF, CHAR_CLOSE,
        CHAR_OPEN, CHAR_E, CHAR_CLOSE,
        CHAR_OPEN, CHAR_A, CHAR_CLOSE
    };

    // clock
    always #5 i_clk = ~i_clk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // payload byte that rarely hits a delimiter
    function automatic t_rx data_byte();
        t_rx v;
        v = t_rx'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) v = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
        if ((v == CHAR_OPEN || v == CHAR_CLOSE) && $urandom_range(0, 19) != 0) v ^= 8'h01;
        return v;
    endfunction

    // one request on the byte channel; called and left at a falling edge
    task automatic send_byte(input t_rx b, input bit counted);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.data  <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        sb.absorb_byte(b);
        if (counted) bytes_counted++;
        @(negedge i_clk);
    endtask

    // hold the sender until every closed frame has come out
    task automatic wait_drained();
        rx_if.valid <= 1'b0;
        @(negedge i_clk);
        while (sb.decoded_q.size() != 0) @(negedge i_clk);
    endtask

    // one random frame, a broken frame or some line noise
    task automatic send_random_group();
        int  pick;
        int  r;
        int  len;
        int  natural_len;
        t_rx cmd;
        pick = $urandom_range(0, 99);
        if (pick >= 90) begin
            repeat ($urandom_range(1, 3))
                send_byte(($urandom_range(0, 3) == 0) ? CHAR_CLOSE : t_rx'($urandom_range(0, 255)),
                          1'b0);
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 17)      begin cmd = CHAR_S; natural_len = 3; end
        else if (r < 34) begin cmd = CHAR_G; natural_len = 3; end
        else if (r < 51) begin cmd = CHAR_A; natural_len = ALERT_BYTES; end
        else if (r < 68) begin cmd = CHAR_M; natural_len = 2; end
        else if (r < 82) begin cmd = CHAR_E; natural_len = 0; end
        else begin
            cmd = data_byte();
            natural_len = $urandom_range(0, 3);
        end
        r = $urandom_range(0, 99);
        if (r < 60)      len = natural_len;
        else if (r < 85) len = $urandom_range(0, natural_len);
        else             len = $urandom_range(0, 13);
        send_byte(CHAR_OPEN, 1'b1);
        send_byte(cmd, 1'b1);
        // sometimes resend the current meters so nothing changes
        if (cmd == CHAR_S && len == 3 && $urandom_range(0, 2) == 0) begin
            send_byte(sb.hunger, 1'b1);
            send_byte(sb.happy, 1'b1);
            send_byte(sb.thirst, 1'b1);
        end else begin
            repeat (len) send_byte(data_byte(), 1'b1);
        end
        if (pick < 82) send_byte(CHAR_CLOSE, 1'b1);
    endtask

    // stretches with no idling on either side
    initial begin
        forever begin
            repeat ($urandom_range(50, 300)) @(posedge i_clk);
            calm = ($urandom_range(0, 3) == 0);
        end
    end

    // result side stalls
    initial begin
        int stall_left;
        stall_left = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) sb.check_result(res_if.data);
    end

    // stimulus and end of run
    initial begin
        bit paused_mid;
        paused_mid    = 1'b0;
        bytes_counted = 0;
        i_rst_n       = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.data    = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed_bytes[i]) send_byte(directed_bytes[i], 1'b1);
        wait_drained();
        bytes_counted = 0;
        while (bytes_counted < RANDOM_BYTES) begin
            send_random_group();
            if (!paused_mid && bytes_counted >= RANDOM_BYTES / 2) begin
                wait_drained();
                paused_mid = 1'b1;
            end
        end
        wait_drained();
        repeat (20) @(negedge i_clk);
        if (sb.decoded_q.size() != 0)
            sb.report_mismatch($sformatf("%0d frames never delivered", sb.decoded_q.size()));
        if (sb.errors == 0) begin
            $display("brace_framed_command_receiver: match");
        end else begin
            $display("brace_framed_command_receiver: mismatch");
        end
        $finish;
    end

    // timeout
    initial begin
        #20ms;
        $display("brace_framed_command_receiver: mismatch");
        $finish;
    end

endmodule
